// File: rtl/core/session_slot_table_unit_defines.svh
// ----------------------------------------------------------------------------
// session slot table unit assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SESSION_SLOT_TABLE_UNIT_DEFINES_SVH
`define SESSION_SLOT_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define SST_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("session slot table check failed");

// next-cycle implication
`define SST_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("session slot table check failed");

`endif

// File: rtl/core/sst_pkg.sv
// ----------------------------------------------------------------------------
// session slot table package
// transfer payload types, action and status codes, register indexes
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int WORD_W  = 32;
   localparam int WORD_BW = 5;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SESSION_BASE = 4'd1;

   localparam logic [1:0] ACT_ACCEPT  = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_SEARCH  = 2'd2;
   localparam logic [1:0] ACT_NONE    = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;
   localparam logic [1:0] STAT_FREE  = 2'd3;

   localparam logic [6:0]  SLOTS_IN_USE_RST = 7'd64;
   localparam logic [15:0] SESSION_BASE_RST = 16'd1;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] sess_id;
      logic [31:0] conn_handle;
   } sst_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_id;
      logic [31:0] found_handle;
      logic [6:0]  active_count;
   } sst_rsp_type;

endpackage

// File: rtl/core/session_slot_table_unit.sv
// ----------------------------------------------------------------------------
// session slot table unit
// first-free session slot allocator with handle store and release/search
// ----------------------------------------------------------------------------
// A transfer is taken on start while busy is low. Accept, release and search
// of an in-range id pass through the data state: the accept cycle issues a
// read of the used-bit row, and of the handle memory for release and search,
// the next cycle checks or allocates, writes back, and the result strobes on
// rsp_valid in the cycle after, with busy low again so the next transfer may
// start there. An accept with no candidate row, an id out of range and action
// three answer in the next cycle with no memory access. The wait comes from
// the synchronous read of the used map and handle memories plus the write
// back, which completes before the next transfer reads. Results cannot be
// held off: rsp_valid is high for exactly one cycle per transfer.
// Configuration writes are always ready and take effect at once. No clearing
// pass follows reset: each used-bit row has a valid flag cleared by reset.
module session_slot_table_unit #(
   parameter int SLOTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  sst_pkg::sst_req_type            req_data,
   output logic                            rsp_valid,
   output sst_pkg::sst_rsp_type            rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sst_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sst_pkg::*;

   localparam int ROWS    = (SLOTS + WORD_W - 1) / WORD_W;
   localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SX_W    = ROW_AW + WORD_BW;
   localparam int SLOT_AW = $clog2(SLOTS);
   localparam int LIM_W   = ($clog2(SLOTS + 1) > 7) ? $clog2(SLOTS + 1) : 7;

   localparam int STATE_W = 1;
   localparam logic [STATE_W-1:0] ST_IDLE = 1'b0;
   localparam logic [STATE_W-1:0] ST_DATA = 1'b1;

   // control state
   logic [STATE_W-1:0] state_ff, state_in;
   logic [6:0]         count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         slots_in_use_ff;
   logic [15:0]        session_base_ff;

   // per-transfer payload
   logic [1:0]         act_ff, act_in;
   logic [SX_W-1:0]    slot_ff, slot_in;
   logic [31:0]        hdl_ff, hdl_in;
   sst_rsp_type        rsp_data_ff, rsp_data_in;

   logic [LIM_W-1:0]   slots_ext;
   logic [LIM_W-1:0]   lim;
   logic [15:0]        id_off;
   logic               in_range;

   // used map port
   logic               map_rd_en;
   logic [ROW_AW-1:0]  map_rd_row;
   logic [WORD_W-1:0]  map_rd_word;
   logic               pick_found;
   logic [ROW_AW-1:0]  pick_row;
   logic               map_wr_en;
   logic [ROW_AW-1:0]  map_wr_row;
   logic [WORD_W-1:0]  map_wr_word;

   // handle memory port
   logic               hr_wr_en;
   logic [SLOT_AW-1:0] hr_wr_addr;
   logic               hr_rd_en;
   logic [SLOT_AW-1:0] hr_rd_addr;
   logic [31:0]        hr_rd_data;

   // free bit search in the row read for an accept
   logic               free_found;
   logic [WORD_BW-1:0] free_bit;
   logic [SX_W-1:0]    free_slot;
   logic [WORD_BW-1:0] sel_bit;

   sst_used_map #(
      .SLOTS (SLOTS)
   ) u_used_map (
      .clock      (clock),
      .reset      (reset),
      .lim        (lim),
      .rd_en      (map_rd_en),
      .rd_row     (map_rd_row),
      .rd_word    (map_rd_word),
      .pick_found (pick_found),
      .pick_row   (pick_row),
      .wr_en      (map_wr_en),
      .wr_row     (map_wr_row),
      .wr_word    (map_wr_word)
   );

   sst_handle_ram #(
      .SLOTS (SLOTS)
   ) u_handle_ram (
      .clock   (clock),
      .wr_en   (hr_wr_en),
      .wr_addr (hr_wr_addr),
      .wr_data (hdl_ff),
      .rd_en   (hr_rd_en),
      .rd_addr (hr_rd_addr),
      .rd_data (hr_rd_data)
   );

   // effective limit: configured count capped at the table size
   assign slots_ext = LIM_W'(slots_in_use_ff);
   assign lim       = (slots_ext > LIM_W'(SLOTS)) ? LIM_W'(SLOTS) : slots_ext;

   // id to slot, wrapping in 16 bits
   assign id_off   = req_data.sess_id - session_base_ff;
   assign in_range = id_off < 16'(lim);

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // lowest free bit of the row, bits at or above the limit count as used
   always_comb begin
      free_found = 1'b0;
      free_bit   = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (!map_rd_word[b] &&
             (16'({slot_ff[SX_W-1:WORD_BW], WORD_BW'(b)}) < 16'(lim))) begin
            free_found = 1'b1;
            free_bit   = WORD_BW'(b);
         end
      end
   end

   assign free_slot = {slot_ff[SX_W-1:WORD_BW], free_bit};
   assign sel_bit   = slot_ff[WORD_BW-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      act_in       = act_ff;
      slot_in      = slot_ff;
      hdl_in       = hdl_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      map_rd_en    = 1'b0;
      map_rd_row   = pick_row;
      map_wr_en    = 1'b0;
      map_wr_row   = slot_ff[SX_W-1:WORD_BW];
      map_wr_word  = map_rd_word;
      hr_wr_en     = 1'b0;
      hr_wr_addr   = free_slot[SLOT_AW-1:0];
      hr_rd_en     = 1'b0;
      hr_rd_addr   = id_off[SLOT_AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in                   = req_data.action;
               hdl_in                   = req_data.conn_handle;
               rsp_data_in.status       = STAT_OK;
               rsp_data_in.granted_id   = '0;
               rsp_data_in.found_handle = '0;
               case (req_data.action)
                  ACT_ACCEPT: begin
                     if (pick_found) begin
                        // fetch the first row with room, finish next cycle
                        map_rd_en  = 1'b1;
                        map_rd_row = pick_row;
                        slot_in    = {pick_row, WORD_BW'(0)};
                        state_in   = ST_DATA;
                     end else begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = STAT_FULL;
                     end
                  end
                  ACT_RELEASE, ACT_SEARCH: begin
                     if (in_range) begin
                        map_rd_en  = 1'b1;
                        map_rd_row = id_off[SX_W-1:WORD_BW];
                        hr_rd_en   = 1'b1;
                        slot_in    = id_off[SX_W-1:0];
                        state_in   = ST_DATA;
                     end else begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = STAT_RANGE;
                     end
                  end
                  default: begin
                     // no operation, answer at once
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DATA: begin
            state_in                 = ST_IDLE;
            rsp_valid_in             = 1'b1;
            rsp_data_in.status       = STAT_OK;
            rsp_data_in.granted_id   = '0;
            rsp_data_in.found_handle = '0;
            case (act_ff)
               ACT_ACCEPT: begin
                  if (free_found) begin
                     // claim the slot and store its handle
                     map_wr_en   = 1'b1;
                     map_wr_word = map_rd_word | (WORD_W'(1) << free_bit);
                     hr_wr_en    = 1'b1;
                     count_in    = count_ff + 7'd1;
                     rsp_data_in.granted_id = session_base_ff + 16'(free_slot);
                  end else begin
                     rsp_data_in.status = STAT_FULL;
                  end
               end
               ACT_RELEASE: begin
                  if (map_rd_word[sel_bit]) begin
                     map_wr_en   = 1'b1;
                     map_wr_word = map_rd_word & ~(WORD_W'(1) << sel_bit);
                     count_in    = (count_ff == 7'd0) ? 7'd0 : count_ff - 7'd1;
                  end else begin
                     rsp_data_in.status = STAT_FREE;
                  end
               end
               ACT_SEARCH: begin
                  if (map_rd_word[sel_bit]) begin
                     rsp_data_in.found_handle = hr_rd_data;
                  end else begin
                     rsp_data_in.status = STAT_FREE;
                  end
               end
               default: begin
                  rsp_data_in.status = STAT_OK;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // count after this transfer
      if (rsp_valid_in) begin
         rsp_data_in.active_count = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         slots_in_use_ff <= SLOTS_IN_USE_RST;
         session_base_ff <= SESSION_BASE_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_SLOTS_IN_USE: slots_in_use_ff <= csr_data[6:0];
               CSR_SESSION_BASE: session_base_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      slot_ff     <= slot_in;
      hdl_ff      <= hdl_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

// File: rtl/core/sst_handle_ram.sv
// ----------------------------------------------------------------------------
// session slot table handle memory
// one stored connection handle per slot, registered read
// ----------------------------------------------------------------------------
module sst_handle_ram #(
   parameter int SLOTS = 64,
   localparam int AW = $clog2(SLOTS)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);
   logic [31:0] hdl_mem_ff [SLOTS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdl_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hdl_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/sst_used_map.sv
// ----------------------------------------------------------------------------
// session slot table used map
// used bits in 32-bit rows, row valid and row full flags, free row pick
// ----------------------------------------------------------------------------
module sst_used_map #(
   parameter int SLOTS = 64,
   localparam int ROWS = (SLOTS + sst_pkg::WORD_W - 1) / sst_pkg::WORD_W,
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int LIM_W = ($clog2(SLOTS + 1) > 7) ? $clog2(SLOTS + 1) : 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [LIM_W-1:0]            lim,
   input  logic                        rd_en,
   input  logic [ROW_AW-1:0]           rd_row,
   output logic [sst_pkg::WORD_W-1:0]  rd_word,
   output logic                        pick_found,
   output logic [ROW_AW-1:0]           pick_row,
   input  logic                        wr_en,
   input  logic [ROW_AW-1:0]           wr_row,
   input  logic [sst_pkg::WORD_W-1:0]  wr_word
);
   import sst_pkg::*;

   logic [WORD_W-1:0] map_mem_ff [ROWS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_valid_ff;
   logic [ROWS-1:0]   valid_ff;
   logic [ROWS-1:0]   full_ff;
   logic [LIM_W:0]    lim_rows;

   // rows that hold at least one slot below the limit
   assign lim_rows = ({1'b0, lim} + (LIM_W + 1)'(WORD_W - 1)) >> WORD_BW;

   always_comb begin
      pick_found = 1'b0;
      pick_row   = '0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (!full_ff[r] && ((LIM_W + 1)'(r) < lim_rows)) begin
            pick_found = 1'b1;
            pick_row   = ROW_AW'(r);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem_ff[wr_row] <= wr_word;
      end
      if (rd_en) begin
         rd_data_ff  <= map_mem_ff[rd_row];
         rd_valid_ff <= valid_ff[rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         full_ff  <= '0;
      end else if (wr_en) begin
         valid_ff[wr_row] <= 1'b1;
         full_ff[wr_row]  <= &wr_word;
      end
   end

   // a row never written reads as all free
   assign rd_word = rd_valid_ff ? rd_data_ff : '0;
endmodule

// File: rtl/core/sst_checker.sv
// ----------------------------------------------------------------------------
// session slot table port checker
// timing of busy and results, field zeroing on errors
// ----------------------------------------------------------------------------
`include "session_slot_table_unit_defines.svh"

module sst_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input sst_pkg::sst_req_type            req_data,
   input logic                            rsp_valid,
   input sst_pkg::sst_rsp_type            rsp_data
);
   import sst_pkg::*;

   // a result always lands with the unit free again
   `SST_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)

   // busy is followed in the next cycle by a result with busy low
   `SST_ASSERT_NXT(a_busy_done, clock, reset, busy, rsp_valid && !busy)

   // a no-operation transfer answers next cycle with ok and zero fields
   `SST_ASSERT_NXT(a_nop_rsp, clock, reset,
      start && !busy && (req_data.action == ACT_NONE),
      rsp_valid && (rsp_data.status == STAT_OK) && (rsp_data.granted_id == 16'd0) &&
      (rsp_data.found_handle == 32'd0))

   // failed transfers grant nothing and find nothing
   `SST_ASSERT_IMP(a_err_zero, clock, reset,
      rsp_valid && (rsp_data.status != STAT_OK),
      (rsp_data.granted_id == 16'd0) && (rsp_data.found_handle == 32'd0))
endmodule

bind session_slot_table_unit sst_checker u_sst_checker (.*);

// File: verif/session_slot_table_unit_tb.sv
// ----------------------------------------------------------------------------
// session slot table unit testbench
// drives accept, release and search commands plus register writes, keeps a
// shadow copy of the slot table and compares every answer field by field
// ----------------------------------------------------------------------------
module session_slot_table_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sst_pkg::*;

   localparam int SLOTS       = 64;
   localparam int HALF_PERIOD = 10;
   localparam int RESET_TICKS = 12;
   localparam int CYCLE_LIMIT = 100_000;
   localparam int DIR_ROWS    = 30;
   localparam int PHASES      = 8;
   localparam int TAIL_TICKS  = 4;

   // register index the block does not decode, writes to it must do nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 4'hF;

   // directed rows: checked against a typed answer, against the shadow table,
   // or a register write
   typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      sst_req_type           req;
      sst_rsp_type           want;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  start     = 1'b0;
   logic                  busy;
   sst_req_type           req_data  = '0;
   logic                  rsp_valid;
   sst_rsp_type           rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // shadow copy of the table and its two registers
   bit          slot_taken [SLOTS];
   logic [31:0] slot_conn  [SLOTS];
   logic [6:0]  taken_count = '0;
   logic [6:0]  limit_reg   = SLOTS_IN_USE_RST;
   logic [15:0] base_reg    = SESSION_BASE_RST;

   // answers owed by the block, oldest first
   sst_rsp_type answers_due [$];

   int mismatch_count = 0;
   int cycle_count    = 0;

   // after reset: limit 64, base 1, table empty
   script_row_type directed_script [DIR_ROWS] = '{
      // empty table: free slot, id just below the base, idle action at all ones
      '{ROW_TYPED, '{ACT_SEARCH, 16'h0001, 32'h0}, '{STAT_FREE, 16'h0, 32'h0, 7'd0}, '0, '0},
      '{ROW_TYPED, '{ACT_RELEASE, 16'h0000, 32'hFFFFFFFF},
        '{STAT_RANGE, 16'h0, 32'h0, 7'd0}, '0, '0},
      '{ROW_TYPED, '{ACT_NONE, 16'hFFFF, 32'hFFFFFFFF}, '{STAT_OK, 16'h0, 32'h0, 7'd0}, '0, '0},
      // first two grants, all-ones and all-zero handles
      '{ROW_TYPED, '{ACT_ACCEPT, 16'hFFFF, 32'hFFFFFFFF},
        '{STAT_OK, 16'h0001, 32'h0, 7'd1}, '0, '0},
      '{ROW_TYPED, '{ACT_ACCEPT, 16'h0000, 32'h0}, '{STAT_OK, 16'h0002, 32'h0, 7'd2}, '0, '0},
      '{ROW_TYPED, '{ACT_SEARCH, 16'h0001, 32'h0},
        '{STAT_OK, 16'h0, 32'hFFFFFFFF, 7'd2}, '0, '0},
      '{ROW_TYPED, '{ACT_SEARCH, 16'h0002, 32'hFFFFFFFF},
        '{STAT_OK, 16'h0, 32'h0, 7'd2}, '0, '0},
      // one past the last slot is out of range, the last slot itself is free
      '{ROW_TYPED, '{ACT_SEARCH, 16'h0041, 32'h0}, '{STAT_RANGE, 16'h0, 32'h0, 7'd2}, '0, '0},
      '{ROW_TYPED, '{ACT_RELEASE, 16'h0040, 32'h0}, '{STAT_FREE, 16'h0, 32'h0, 7'd2}, '0, '0},
      // release, double release, search after release sees a free slot
      '{ROW_TYPED, '{ACT_RELEASE, 16'h0001, 32'h0}, '{STAT_OK, 16'h0, 32'h0, 7'd1}, '0, '0},
      '{ROW_TYPED, '{ACT_RELEASE, 16'h0001, 32'h0}, '{STAT_FREE, 16'h0, 32'h0, 7'd1}, '0, '0},
      '{ROW_TYPED, '{ACT_SEARCH, 16'h0001, 32'h0}, '{STAT_FREE, 16'h0, 32'h0, 7'd1}, '0, '0},
      // lowest free slot is reused
      '{ROW_TYPED, '{ACT_ACCEPT, 16'h1234, 32'hA5A55A5A},
        '{STAT_OK, 16'h0001, 32'h0, 7'd2}, '0, '0},
      '{ROW_PREDICT, '{ACT_SEARCH, 16'h0001, 32'h0}, '0, '0, '0},
      '{ROW_TYPED, '{ACT_NONE, 16'h0002, 32'h12345678}, '{STAT_OK, 16'h0, 32'h0, 7'd2}, '0, '0},
      // zero slot limit: accept is full, every id out of range
      '{ROW_CSR, '0, '0, CSR_SLOTS_IN_USE, 16'h0000},
      '{ROW_TYPED, '{ACT_ACCEPT, 16'h0000, 32'h1}, '{STAT_FULL, 16'h0, 32'h0, 7'd2}, '0, '0},
      '{ROW_TYPED, '{ACT_SEARCH, 16'h0001, 32'h0}, '{STAT_RANGE, 16'h0, 32'h0, 7'd2}, '0, '0},
      // limit above the table size with junk in the upper data bits, top base,
      // and a write to an undecoded index
      '{ROW_CSR, '0, '0, CSR_SLOTS_IN_USE, 16'hFF7F},
      '{ROW_CSR, '0, '0, CSR_SESSION_BASE, 16'hFFFF},
      '{ROW_CSR, '0, '0, CSR_SPARE, 16'hFFFF},
      // granted id wraps past 65535
      '{ROW_TYPED, '{ACT_ACCEPT, 16'h0000, 32'h5555AAAA},
        '{STAT_OK, 16'h0001, 32'h0, 7'd3}, '0, '0},
      '{ROW_TYPED, '{ACT_SEARCH, 16'h0000, 32'h0}, '{STAT_OK, 16'h0, 32'h0, 7'd3}, '0, '0},
      '{ROW_TYPED, '{ACT_RELEASE, 16'hFFFF, 32'h0}, '{STAT_OK, 16'h0, 32'h0, 7'd2}, '0, '0},
      '{ROW_PREDICT, '{ACT_SEARCH, 16'h0001, 32'h0}, '0, '0, '0},
      // zero base
      '{ROW_CSR, '0, '0, CSR_SESSION_BASE, 16'h0000},
      '{ROW_PREDICT, '{ACT_ACCEPT, 16'h0000, 32'hC3C3C3C3}, '0, '0, '0},
      '{ROW_CSR, '0, '0, CSR_SLOTS_IN_USE, 16'h0040},
      '{ROW_PREDICT, '{ACT_SEARCH, 16'h003F, 32'h0}, '0, '0, '0},
      '{ROW_PREDICT, '{ACT_RELEASE, 16'h0040, 32'h0}, '0, '0, '0}
   };

   session_slot_table_unit #(
      .SLOTS(SLOTS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // effective slot limit, clamped to the table size
   function automatic int unsigned table_limit();
      return (limit_reg > SLOTS) ? SLOTS : limit_reg;
   endfunction

   // apply one command to the shadow table and return the answer it owes
   function automatic sst_rsp_type serve_request(sst_req_type q);
      sst_rsp_type a;
      int unsigned lim;
      int unsigned k;
      logic [15:0] slot;
      bit          placed;
      lim    = table_limit();
      a      = '0;
      placed = 1'b0;
      a.status = STAT_OK;
      case (q.action)
         ACT_ACCEPT: begin
            a.status = STAT_FULL;
            // first free slot below the limit wins
            for (k = 0; k < lim && !placed; k++) begin
               if (!slot_taken[k]) begin
                  slot_taken[k] = 1'b1;
                  slot_conn[k]  = q.conn_handle;
                  taken_count   = taken_count + 7'd1;
                  a.granted_id  = base_reg + 16'(k);
                  a.status      = STAT_OK;
                  placed        = 1'b1;
               end
            end
         end
         ACT_RELEASE, ACT_SEARCH: begin
            // ids map back to slots modulo 65536
            slot = q.sess_id - base_reg;
            if (slot >= lim) begin
               a.status = STAT_RANGE;
            end else if (!slot_taken[slot]) begin
               a.status = STAT_FREE;
            end else if (q.action == ACT_RELEASE) begin
               slot_taken[slot] = 1'b0;
               slot_conn[slot]  = '0;
               if (taken_count != 0) begin
                  taken_count = taken_count - 7'd1;
               end
            end else begin
               a.found_handle = slot_conn[slot];
            end
         end
         default: begin
            // idle action: nothing changes
         end
      endcase
      a.active_count = taken_count;
      return a;
   endfunction

   // random command, mostly aimed at slots that are in use
   function automatic sst_req_type draw_request();
      sst_req_type q;
      int unsigned pick;
      int unsigned lim;
      int unsigned slot;
      int unsigned tries;
      q.action      = ACT_ACCEPT;
      q.sess_id     = 16'($urandom);
      q.conn_handle = $urandom;
      lim  = table_limit();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // noise: any action, any id
         q.action = 2'($urandom);
      end else if (pick < 45) begin
         q.action = ACT_ACCEPT;
      end else if (pick < 95) begin
         q.action = (pick < 70) ? ACT_RELEASE : ACT_SEARCH;
         if (lim == 0) begin
            slot = $urandom_range(0, 3);
         end else begin
            slot = $urandom_range(0, lim - 1);
            for (tries = 0; tries < 8 && !slot_taken[slot]; tries++) begin
               slot = $urandom_range(0, lim - 1);
            end
            // now and then just past the limit
            if ($urandom_range(0, 9) == 0) begin
               slot = lim + $urandom_range(0, 1);
            end
         end
         q.sess_id = 16'(base_reg + slot);
      end else begin
         q.action = ACT_NONE;
      end
      return q;
   endfunction

   // present a command and hold it until the block takes the transfer;
   // start stays high so the caller either sends again or lowers it
   task automatic send_item(input sst_req_type q, input bit typed, input sst_rsp_type want);
      sst_rsp_type owed;
      start    <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      owed = serve_request(q);
      answers_due.push_back(typed ? want : owed);
   endtask

   // stop sending and wait until every owed answer is in
   task automatic settle_table();
      start <= 1'b0;
      while (answers_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // one register write; keep_open leaves valid high for a write that follows
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val, input bit keep_open);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (!keep_open) begin
         csr_valid <= 1'b0;
      end
      case (idx)
         CSR_SLOTS_IN_USE: limit_reg = val[6:0];
         CSR_SESSION_BASE: base_reg  = val;
         default: begin
            // undecoded index
         end
      endcase
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // answer checker: every strobed answer against the oldest one owed
   always @(posedge clock) begin
      sst_rsp_type due;
      if (!reset && rsp_valid === 1'b1) begin
         if (answers_due.size() == 0) begin
            $error("answer with nothing owed: status %0d id %0h handle %0h count %0d",
                   rsp_data.status, rsp_data.granted_id, rsp_data.found_handle,
                   rsp_data.active_count);
            mismatch_count++;
         end else begin
            due = answers_due.pop_front();
            check_field("status", 32'(due.status), 32'(rsp_data.status));
            check_field("granted_id", 32'(due.granted_id), 32'(rsp_data.granted_id));
            check_field("found_handle", due.found_handle, rsp_data.found_handle);
            check_field("active_count", 32'(due.active_count), 32'(rsp_data.active_count));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int          r;
      int          p;
      int          n;
      int unsigned phase_len;
      int unsigned idle_pct;
      logic [6:0]  lim_pick;
      logic [15:0] base_pick;

      foreach (slot_taken[i]) begin
         slot_taken[i] = 1'b0;
         slot_conn[i]  = '0;
      end

      // synchronous reset, held at the start of the run
      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      // directed part, walked row by row
      for (r = 0; r < DIR_ROWS; r++) begin
         if (directed_script[r].kind == ROW_CSR) begin
            // registers only change on an idle block
            settle_table();
            write_register(directed_script[r].reg_idx, directed_script[r].reg_val,
                           (r + 1 < DIR_ROWS) && directed_script[r + 1].kind == ROW_CSR);
         end else begin
            send_item(directed_script[r].req, directed_script[r].kind == ROW_TYPED,
                      directed_script[r].want);
         end
      end

      // random phases, each with its own register setting and idling
      for (p = 0; p < PHASES; p++) begin
         settle_table();
         base_pick = 16'($urandom);
         case (p)
            0: begin lim_pick = 7'd64; base_pick = 16'h0001; end
            1: begin lim_pick = 7'd1;  base_pick = 16'hFFFF; end
            2: begin lim_pick = 7'd127; base_pick = 16'h0000; end
            3: lim_pick = 7'd0;
            4: lim_pick = 7'($urandom_range(2, 8));
            5: begin lim_pick = 7'd64; base_pick = 16'hFFF0; end
            6: lim_pick = 7'($urandom_range(1, 64));
            default: lim_pick = 7'($urandom_range(65, 127));
         endcase
         // upper data bits of the limit write are junk the block must drop
         write_register(CSR_SLOTS_IN_USE, {9'($urandom), lim_pick}, 1'b1);
         write_register(CSR_SESSION_BASE, base_pick, 1'b0);

         // a zero limit answers every accept, release and search with full or out of range, keep it short
         phase_len = (lim_pick == 0) ? 30 : 140;
         case (p % 3)
            0: idle_pct = 0;
            1: idle_pct = 63;
            default: idle_pct = 15;
         endcase

         for (n = 0; n < int'(phase_len); n++) begin
            if (n == int'(phase_len / 2)) begin
               // hold off until the table has answered everything
               settle_table();
            end else if ($urandom_range(0, 99) < idle_pct) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end
            send_item(draw_request(), 1'b0, '0);
         end
      end

      // drain, then let the last strobe settle
      settle_table();
      repeat (TAIL_TICKS) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
